// File: rtl/xmad_pkg.sv
// Shared types, codes and lookup functions for the ModRM/SIB address decoder.
`timescale 1ns / 1ps

package xmad_pkg;

    localparam logic [2:0] SEG_ES = 3'd0;
    localparam logic [2:0] SEG_CS = 3'd1;
    localparam logic [2:0] SEG_SS = 3'd2;
    localparam logic [2:0] SEG_DS = 3'd3;
    localparam logic [2:0] SEG_FS = 3'd4;
    localparam logic [2:0] SEG_GS = 3'd5;

    localparam logic [2:0] REG_ESP = 3'd4;
    localparam logic [2:0] REG_EBP = 3'd5;
    localparam logic [2:0] RM_SIB = 3'd4;
    localparam logic [2:0] RM_DIRECT16 = 3'd6;

    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8 = 2'd1;

    localparam int PADDR_W = 3;
    localparam logic CFG_IDX_ALWAYS_ADD = 1'b0;

    typedef struct packed {
        logic [7:0]  modrm_byte;
        logic [39:0] following_bytes;
        logic        address_size_32;
        logic [5:0]  segment_prefixes;
    } t_ea_req;

    typedef struct packed {
        logic               base_valid;
        logic [2:0]         base_register;
        logic               index_valid;
        logic [2:0]         index_register;
        logic [1:0]         scale_shift;
        logic signed [31:0] displacement;
        logic               wrap_sixteen;
        logic               add_segment;
        logic [2:0]         segment_select;
        logic [2:0]         bytes_used;
    } t_ea_res;

    // Base register of the 16-bit forms, by rm.
    function automatic logic [2:0] base16(input logic [2:0] rm);
        logic [2:0] r;
        case (rm)
            3'd0, 3'd1, 3'd7: r = 3'd3;
            3'd2, 3'd3, 3'd6: r = 3'd5;
            3'd4:             r = 3'd6;
            default:          r = 3'd7;
        endcase
        return r;
    endfunction

    // Index register of the 16-bit forms; only rm 0 to 3 carry one.
    function automatic logic [2:0] index16(input logic [2:0] rm);
        return rm[0] ? 3'd7 : 3'd6;
    endfunction

endpackage

// File: rtl/x86_modrm_address_decode_core.sv
// Top level of the x86 ModRM/SIB effective address decoder with its register port.
`timescale 1ns / 1ps

// Usage:
// An operand beat enters on i_in_valid when o_in_stall is low and carries the
// ModRM byte, the five bytes after it, the address size and the prefix mask.
// The decoded operand leaves on o_out_valid and is taken when i_out_stall is
// low. Each beat yields exactly one result beat.
// An operand beat passes the input register, one level of decode logic and the
// result register in that order, and one beat is taken every cycle while the
// receiver does not stall.
// When the receiver stalls, the result register holds its beat and the input
// register keeps taking a beat until it is full too; o_in_stall then rises in
// the same cycle that the result register cannot move.
// Reset empties both registers and clears always_add_segment.
// always_add_segment sits at byte address 0 of the APB port; the user must write
// it only while no beat is in flight, as the block does not enforce this. pready is always high.

module x86_modrm_address_decode_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_modrm_byte,
    input  logic [39:0]                       i_following_bytes,
    input  logic                              i_address_size_32,
    input  logic [5:0]                        i_segment_prefixes,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_base_valid,
    output logic [2:0]                        o_base_register,
    output logic                              o_index_valid,
    output logic [2:0]                        o_index_register,
    output logic [1:0]                        o_scale_shift,
    output logic signed [31:0]                o_displacement,
    output logic                              o_wrap_sixteen,
    output logic                              o_add_segment,
    output logic [2:0]                        o_segment_select,
    output logic [2:0]                        o_bytes_used,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [xmad_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic              r_always_add;
    logic              r_s1_valid;
    xmad_pkg::t_ea_req r_s1_req;
    logic              r_out_valid;
    xmad_pkg::t_ea_res r_out;
    xmad_pkg::t_ea_res dec_res;
    xmad_pkg::t_ea_req in_req;
    logic              out_move;
    logic              s1_move;
    logic              in_take;
    logic              cfg_sel;

    assign pready = 1'b1;
    assign cfg_sel = (paddr[2] == xmad_pkg::CFG_IDX_ALWAYS_ADD);
    assign prdata = cfg_sel ? {31'd0, r_always_add} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_always_add <= 1'b0;
        end else if (psel && penable && pwrite && cfg_sel) begin
            r_always_add <= pwdata[0];
        end
    end

    assign out_move = !r_out_valid || !i_out_stall;
    assign s1_move = !r_s1_valid || out_move;
    assign o_in_stall = !s1_move;
    assign in_take = i_in_valid && s1_move;

    assign in_req.modrm_byte = i_modrm_byte;
    assign in_req.following_bytes = i_following_bytes;
    assign in_req.address_size_32 = i_address_size_32;
    assign in_req.segment_prefixes = i_segment_prefixes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_move) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_req <= in_req;
        end
        if (out_move && r_s1_valid) begin
            r_out <= dec_res;
        end
    end

    xmad_decode u_decode (
        .i_req                (r_s1_req),
        .i_always_add_segment (r_always_add),
        .o_res                (dec_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_base_valid = r_out.base_valid;
    assign o_base_register = r_out.base_register;
    assign o_index_valid = r_out.index_valid;
    assign o_index_register = r_out.index_register;
    assign o_scale_shift = r_out.scale_shift;
    assign o_displacement = r_out.displacement;
    assign o_wrap_sixteen = r_out.wrap_sixteen;
    assign o_add_segment = r_out.add_segment;
    assign o_segment_select = r_out.segment_select;
    assign o_bytes_used = r_out.bytes_used;

    // An unused base or index field reads as zero.
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_base_valid || (o_base_register == 3'd0))
            && (o_index_valid || ((o_index_register == 3'd0) && (o_scale_shift == 2'd0)))))
        else $error("unused base or index field is not zero");

    // The 16-bit offset wrap only applies to register-based 16-bit forms.
    a_wrap_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_wrap_sixteen) |-> (o_base_valid && (o_bytes_used <= 3'd2)))
        else $error("wrap without a 16-bit base form");

    // A beat held in the input register with a free result register moves on.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !(o_out_valid && i_out_stall)) |=> o_out_valid)
        else $error("decoded beat was lost");

    // Segment select stays within the six segments and bytes used within five.
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_segment_select <= xmad_pkg::SEG_GS) && (o_bytes_used <= 3'd5)))
        else $error("segment or byte count out of range");

endmodule

// File: rtl/xmad_decode.sv
// Combinational decode of one memory operand into base, index, displacement and segment.
`timescale 1ns / 1ps

module xmad_decode (
    input  xmad_pkg::t_ea_req i_req,
    input  logic              i_always_add_segment,
    output xmad_pkg::t_ea_res o_res
);

    logic [1:0]  mode;
    logic [2:0]  rm;
    logic [39:0] fb;
    logic        sib_present;
    logic [2:0]  base32;
    logic [2:0]  sib_index;
    logic [31:0] window;
    logic        default_ss;
    logic        has_override;
    logic [2:0]  pfx_seg;

    assign mode = i_req.modrm_byte[7:6];
    assign rm = i_req.modrm_byte[2:0];
    assign fb = i_req.following_bytes;
    assign sib_present = (rm == xmad_pkg::RM_SIB);
    assign base32 = sib_present ? fb[2:0] : rm;
    assign sib_index = fb[5:3];
    assign window = sib_present ? fb[39:8] : fb[31:0];
    assign has_override = (i_req.segment_prefixes != 6'd0);

    always_comb begin
        if (i_req.segment_prefixes[0]) begin
            pfx_seg = xmad_pkg::SEG_ES;
        end else if (i_req.segment_prefixes[1]) begin
            pfx_seg = xmad_pkg::SEG_CS;
        end else if (i_req.segment_prefixes[2]) begin
            pfx_seg = xmad_pkg::SEG_SS;
        end else if (i_req.segment_prefixes[3]) begin
            pfx_seg = xmad_pkg::SEG_DS;
        end else if (i_req.segment_prefixes[4]) begin
            pfx_seg = xmad_pkg::SEG_FS;
        end else begin
            pfx_seg = xmad_pkg::SEG_GS;
        end
    end

    always_comb begin
        o_res = '0;
        default_ss = 1'b0;
        if (i_req.address_size_32) begin
            o_res.bytes_used = {2'b00, sib_present};
            if (sib_present && (sib_index != xmad_pkg::REG_ESP)) begin
                o_res.index_valid = 1'b1;
                o_res.index_register = sib_index;
                o_res.scale_shift = fb[7:6];
            end
            o_res.base_valid = 1'b1;
            o_res.base_register = base32;
            if (mode == xmad_pkg::MOD_NODISP) begin
                if (base32 == xmad_pkg::REG_EBP) begin
                    o_res.base_valid = 1'b0;
                    o_res.base_register = 3'd0;
                    o_res.displacement = window;
                    o_res.bytes_used = o_res.bytes_used + 3'd4;
                end
            end else if (mode == xmad_pkg::MOD_DISP8) begin
                o_res.displacement = {{24{window[7]}}, window[7:0]};
                o_res.bytes_used = o_res.bytes_used + 3'd1;
            end else begin
                o_res.displacement = window;
                o_res.bytes_used = o_res.bytes_used + 3'd4;
            end
            default_ss = o_res.base_valid && ((base32 == xmad_pkg::REG_EBP)
                || (base32 == xmad_pkg::REG_ESP));
        end else begin
            if ((mode == xmad_pkg::MOD_NODISP) && (rm == xmad_pkg::RM_DIRECT16)) begin
                o_res.displacement = {16'd0, fb[15:0]};
                o_res.bytes_used = 3'd2;
            end else begin
                if (mode == xmad_pkg::MOD_DISP8) begin
                    o_res.displacement = {{24{fb[7]}}, fb[7:0]};
                    o_res.bytes_used = 3'd1;
                end else if (mode != xmad_pkg::MOD_NODISP) begin
                    o_res.displacement = {16'd0, fb[15:0]};
                    o_res.bytes_used = 3'd2;
                end
                o_res.base_valid = 1'b1;
                o_res.base_register = xmad_pkg::base16(rm);
                if (!rm[2]) begin
                    o_res.index_valid = 1'b1;
                    o_res.index_register = xmad_pkg::index16(rm);
                end
                o_res.wrap_sixteen = 1'b1;
                default_ss = (rm == 3'd2) || (rm == 3'd3) || (rm == 3'd6);
            end
        end
        o_res.add_segment = has_override || i_always_add_segment;
        if (has_override) begin
            o_res.segment_select = pfx_seg;
        end else begin
            o_res.segment_select = default_ss ? xmad_pkg::SEG_SS : xmad_pkg::SEG_DS;
        end
    end

endmodule

// File: dv/x86_modrm_address_decode_core_test.sv
// Self-checking testbench for the ModRM/SIB effective address decoder core.
`timescale 1ns / 1ps

module x86_modrm_address_decode_core_test;

    localparam int PHASE_BEATS = 360;
    localparam int HOLD_CYCLES = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PADDR_W = xmad_pkg::PADDR_W;
    localparam logic [PADDR_W-1:0] CFG_ADDR_ALWAYS_ADD =
        PADDR_W'(4 * int'(xmad_pkg::CFG_IDX_ALWAYS_ADD));

    localparam logic [2:0] REG_EBX = 3'd3;
    localparam logic [2:0] REG_ESI = 3'd6;
    localparam logic [2:0] REG_EDI = 3'd7;

    typedef struct {
        logic              typed;
        xmad_pkg::t_ea_req op;
        xmad_pkg::t_ea_res want;
    } t_op_row;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [7:0]        i_modrm_byte = '0;
    logic [39:0]       i_following_bytes = '0;
    logic              i_address_size_32 = 1'b0;
    logic [5:0]        i_segment_prefixes = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_base_valid;
    logic [2:0]        o_base_register;
    logic              o_index_valid;
    logic [2:0]        o_index_register;
    logic [1:0]        o_scale_shift;
    logic signed [31:0] o_displacement;
    logic              o_wrap_sixteen;
    logic              o_add_segment;
    logic [2:0]        o_segment_select;
    logic [2:0]        o_bytes_used;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    xmad_pkg::t_ea_res awaited_decodes[$];
    t_op_row     directed_rows[$];
    logic        add_always = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_reqs = 0;
    int          fail_count = 0;
    int          beats_sent = 0;
    int          beats_checked = 0;
    int          sib_beats = 0;
    int          wide_beats = 0;
    longint      cycles = 0;

    x86_modrm_address_decode_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_modrm_byte       (i_modrm_byte),
        .i_following_bytes  (i_following_bytes),
        .i_address_size_32  (i_address_size_32),
        .i_segment_prefixes (i_segment_prefixes),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_base_valid       (o_base_valid),
        .o_base_register    (o_base_register),
        .o_index_valid      (o_index_valid),
        .o_index_register   (o_index_register),
        .o_scale_shift      (o_scale_shift),
        .o_displacement     (o_displacement),
        .o_wrap_sixteen     (o_wrap_sixteen),
        .o_add_segment      (o_add_segment),
        .o_segment_select   (o_segment_select),
        .o_bytes_used       (o_bytes_used),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic xmad_pkg::t_ea_res decode_operand(input xmad_pkg::t_ea_req op,
                                                         input logic always_add);
        xmad_pkg::t_ea_res r;
        logic [1:0]  md;
        logic [2:0]  rm;
        logic [2:0]  b;
        logic [7:0]  sib;
        logic [39:0] rest;
        logic [2:0]  pos;
        logic        use_ss;
        r = '0;
        pos = '0;
        use_ss = 1'b0;
        md = op.modrm_byte[7:6];
        rm = op.modrm_byte[2:0];
        if (op.address_size_32) begin
            b = rm;
            rest = op.following_bytes;
            if (rm == xmad_pkg::RM_SIB) begin
                sib = op.following_bytes[7:0];
                rest = op.following_bytes >> 8;
                pos = 3'd1;
                b = sib[2:0];
                if (sib[5:3] != xmad_pkg::REG_ESP) begin
                    r.index_valid = 1'b1;
                    r.index_register = sib[5:3];
                    r.scale_shift = sib[7:6];
                end
            end
            r.base_valid = 1'b1;
            r.base_register = b;
            if (md == xmad_pkg::MOD_NODISP) begin
                if (b == xmad_pkg::REG_EBP) begin
                    r.base_valid = 1'b0;
                    r.base_register = '0;
                    r.displacement = rest[31:0];
                    pos = pos + 3'd4;
                end
            end else if (md == xmad_pkg::MOD_DISP8) begin
                r.displacement = {{24{rest[7]}}, rest[7:0]};
                pos = pos + 3'd1;
            end else begin
                r.displacement = rest[31:0];
                pos = pos + 3'd4;
            end
            use_ss = r.base_valid && (b == xmad_pkg::REG_EBP || b == xmad_pkg::REG_ESP);
        end else if (md == xmad_pkg::MOD_NODISP && rm == xmad_pkg::RM_DIRECT16) begin
            r.displacement = {16'h0000, op.following_bytes[15:0]};
            pos = 3'd2;
        end else begin
            if (md == xmad_pkg::MOD_DISP8) begin
                r.displacement = {{24{op.following_bytes[7]}}, op.following_bytes[7:0]};
                pos = 3'd1;
            end else if (md != xmad_pkg::MOD_NODISP) begin
                r.displacement = {16'h0000, op.following_bytes[15:0]};
                pos = 3'd2;
            end
            r.base_valid = 1'b1;
            case (rm)
                3'd0, 3'd1, 3'd7: r.base_register = REG_EBX;
                3'd2, 3'd3, 3'd6: r.base_register = xmad_pkg::REG_EBP;
                3'd4:             r.base_register = REG_ESI;
                default:          r.base_register = REG_EDI;
            endcase
            if (rm < 3'd4) begin
                r.index_valid = 1'b1;
                r.index_register = rm[0] ? REG_EDI : REG_ESI;
            end
            r.wrap_sixteen = 1'b1;
            use_ss = (rm == 3'd2 || rm == 3'd3 || rm == 3'd6);
        end
        r.segment_select = use_ss ? xmad_pkg::SEG_SS : xmad_pkg::SEG_DS;
        for (int s = int'(xmad_pkg::SEG_GS); s >= int'(xmad_pkg::SEG_ES); s--) begin
            if (op.segment_prefixes[s]) r.segment_select = 3'(s);
        end
        r.add_segment = (op.segment_prefixes != '0) || always_add;
        r.bytes_used = pos;
        return r;
    endfunction

    function automatic xmad_pkg::t_ea_res decoded(input logic bv, input logic [2:0] br,
                                        input logic iv,
                                        input logic [2:0] ir, input logic [1:0] sc,
                                        input logic [31:0] disp, input logic wr,
                                        input logic adds, input logic [2:0] seg,
                                        input logic [2:0] used);
        xmad_pkg::t_ea_res r;
        r = {bv, br, iv, ir, sc, disp, wr, adds, seg, used};
        return r;
    endfunction

    function automatic t_op_row op_row(input logic typed, input logic [7:0] modrm,
                                       input logic [39:0] fb, input logic a32,
                                       input logic [5:0] pfx, input xmad_pkg::t_ea_res want);
        t_op_row row;
        row.typed = typed;
        row.op = {modrm, fb, a32, pfx};
        row.want = want;
        return row;
    endfunction

    function automatic xmad_pkg::t_ea_req random_operand();
        xmad_pkg::t_ea_req op;
        op.modrm_byte = 8'($urandom);
        op.following_bytes = {8'($urandom), 32'($urandom)};
        op.address_size_32 = 1'($urandom);
        case ($urandom_range(3))
            0:       op.segment_prefixes = '0;
            1:       op.segment_prefixes = 6'(1 << $urandom_range(5));
            default: op.segment_prefixes = 6'($urandom);
        endcase
        if ($urandom_range(3) == 0) begin
            op.address_size_32 = 1'b1;
            op.modrm_byte[2:0] = xmad_pkg::RM_SIB;
            if ($urandom_range(2) == 0) begin
                op.modrm_byte[7:6] = xmad_pkg::MOD_NODISP;
                op.following_bytes[2:0] = xmad_pkg::REG_EBP;
            end
        end
        return op;
    endfunction

    task automatic load_directed();
        xmad_pkg::t_ea_res none;
        none = '0;
        directed_rows.push_back(op_row(1'b1, 8'h06, 40'h00_0000_BEEF, 1'b0, 6'h00,
            decoded(1'b0, 3'd0, 1'b0, 3'd0, 2'd0, 32'h0000_BEEF, 1'b0, 1'b0,
                    xmad_pkg::SEG_DS, 3'd2)));
        directed_rows.push_back(op_row(1'b1, 8'h05, 40'hFF_8000_0000, 1'b1, 6'h00,
            decoded(1'b0, 3'd0, 1'b0, 3'd0, 2'd0, 32'h8000_0000, 1'b0, 1'b0,
                    xmad_pkg::SEG_DS, 3'd4)));
        directed_rows.push_back(op_row(1'b1, 8'h40, 40'h00_0000_0080, 1'b1, 6'h00,
            decoded(1'b1, 3'd0, 1'b0, 3'd0, 2'd0, 32'hFFFF_FF80, 1'b0, 1'b0,
                    xmad_pkg::SEG_DS, 3'd1)));
        directed_rows.push_back(op_row(1'b1, 8'h04, 40'h7F_FFFF_FF25, 1'b1, 6'h00,
            decoded(1'b0, 3'd0, 1'b0, 3'd0, 2'd0, 32'h7FFF_FFFF, 1'b0, 1'b0,
                    xmad_pkg::SEG_DS, 3'd5)));
        directed_rows.push_back(op_row(1'b1, 8'h82, 40'hFF_FFFF_FFFF, 1'b0, 6'h3F,
            decoded(1'b1, 3'd5, 1'b1, 3'd6, 2'd0, 32'h0000_FFFF, 1'b1, 1'b1,
                    xmad_pkg::SEG_ES, 3'd2)));
        directed_rows.push_back(op_row(1'b1, 8'hFD, 40'h12_3456_789A, 1'b1, 6'h20,
            decoded(1'b1, 3'd5, 1'b0, 3'd0, 2'd0, 32'h3456_789A, 1'b0, 1'b1,
                    xmad_pkg::SEG_GS, 3'd4)));
        directed_rows.push_back(op_row(1'b1, 8'h3C, 40'h00_0000_00E4, 1'b1, 6'h00,
            decoded(1'b1, 3'd4, 1'b0, 3'd0, 2'd0, 32'h0000_0000, 1'b0, 1'b0,
                    xmad_pkg::SEG_SS, 3'd1)));
        directed_rows.push_back(op_row(1'b1, 8'h46, 40'h00_0000_007F, 1'b0, 6'h00,
            decoded(1'b1, 3'd5, 1'b0, 3'd0, 2'd0, 32'h0000_007F, 1'b1, 1'b0,
                    xmad_pkg::SEG_SS, 3'd1)));
        directed_rows.push_back(op_row(1'b0, 8'h00, 40'h00_0000_0000, 1'b0, 6'h00, none));
        directed_rows.push_back(op_row(1'b0, 8'h01, 40'hFF_FFFF_FFFF, 1'b0, 6'h02, none));
        directed_rows.push_back(op_row(1'b0, 8'h03, 40'h55_AA55_AA55, 1'b0, 6'h04, none));
        directed_rows.push_back(op_row(1'b0, 8'h04, 40'hAA_55AA_55AA, 1'b0, 6'h08, none));
        directed_rows.push_back(op_row(1'b0, 8'h05, 40'h01_2345_6789, 1'b0, 6'h10, none));
        directed_rows.push_back(op_row(1'b0, 8'h07, 40'h98_7654_3210, 1'b0, 6'h30, none));
        directed_rows.push_back(op_row(1'b0, 8'hC1, 40'hAB_CDEF_1234, 1'b0, 6'h3C, none));
        directed_rows.push_back(op_row(1'b0, 8'h43, 40'h00_0000_0080, 1'b0, 6'h38, none));
        directed_rows.push_back(op_row(1'b0, 8'h84, 40'h80_0000_00C8, 1'b1, 6'h3E, none));
        directed_rows.push_back(op_row(1'b0, 8'h44, 40'h00_0000_FF9D, 1'b1, 6'h00, none));
        directed_rows.push_back(op_row(1'b0, 8'h3B, 40'hFF_FFFF_FFFF, 1'b1, 6'h01, none));
        directed_rows.push_back(op_row(1'b0, 8'h06, 40'h00_0000_1234, 1'b1, 6'h00, none));
        directed_rows.push_back(op_row(1'b0, 8'hC7, 40'h00_FFFF_FFFF, 1'b1, 6'h00, none));
        directed_rows.push_back(op_row(1'b0, 8'h04, 40'hFF_FFFF_FF6D, 1'b1, 6'h00, none));
    endtask

    task automatic send_beat(input xmad_pkg::t_ea_req op, input logic typed,
                             input xmad_pkg::t_ea_res want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_modrm_byte <= op.modrm_byte;
        i_following_bytes <= op.following_bytes;
        i_address_size_32 <= op.address_size_32;
        i_segment_prefixes <= op.segment_prefixes;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        awaited_decodes.push_back(typed ? want : decode_operand(op, add_always));
        beats_sent++;
        if (op.address_size_32) wide_beats++;
        if (op.address_size_32 && op.modrm_byte[2:0] == xmad_pkg::RM_SIB) sib_beats++;
    endtask

    task automatic drain_decoder();
        i_in_valid <= 1'b0;
        while (awaited_decodes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == CFG_ADDR_ALWAYS_ADD) add_always = data[0];
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input logic always_add,
                             input int hold_at, input int pause_at);
        drain_decoder();
        write_reg(CFG_ADDR_ALWAYS_ADD, {31'b0, always_add});
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        for (int n = 0; n < PHASE_BEATS; n++) begin
            if (n == hold_at) hold_reqs++;
            if (n == pause_at) drain_decoder();
            send_beat(random_operand(), 1'b0, '0);
        end
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    initial begin
        int      hold_seen;
        int      hold_left;
        xmad_pkg::t_ea_res want;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (awaited_decodes.size() == 0) begin
                    $error("result beat arrived with no decode outstanding");
                    fail_count++;
                end else begin
                    want = awaited_decodes.pop_front();
                    beats_checked++;
                    cmp_field("base_valid", want.base_valid, o_base_valid);
                    cmp_field("base_register", want.base_register, o_base_register);
                    cmp_field("index_valid", want.index_valid, o_index_valid);
                    cmp_field("index_register", want.index_register, o_index_register);
                    cmp_field("scale_shift", want.scale_shift, o_scale_shift);
                    cmp_field("displacement", want.displacement, o_displacement);
                    cmp_field("wrap_sixteen", want.wrap_sixteen, o_wrap_sixteen);
                    cmp_field("add_segment", want.add_segment, o_add_segment);
                    cmp_field("segment_select", want.segment_select, o_segment_select);
                    cmp_field("bytes_used", want.bytes_used, o_bytes_used);
                end
            end
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        load_directed();
        foreach (directed_rows[k]) begin
            send_beat(directed_rows[k].op, directed_rows[k].typed, directed_rows[k].want);
        end
        run_phase(0, 0, 1'b1, 100, -1);
        run_phase(65, 0, 1'b0, -1, -1);
        run_phase(0, 65, 1'b1, -1, 150);
        run_phase(6, 6, 1'b0, -1, -1);
        drain_decoder();
        $display("Checked %0d of %0d operand beats (%0d 32-bit, %0d with SIB) in %0d cycles.",
                 beats_checked, beats_sent, wide_beats, sib_beats, cycles);
        $display("Both always_add_segment settings, idle and stall mixes and a long output hold.");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/xmad_pkg.sv
rtl/xmad_decode.sv
rtl/x86_modrm_address_decode_core.sv
dv/x86_modrm_address_decode_core_test.sv
